// File: rtl/tcp_pkg.sv
// Package for the text console with pointer.
// Geometry, operation and cell-update codes, and the structs shared between modules.
// No dependencies.
package tcp_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths fixed by the item format
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 11;
    localparam int CELL_W = 16;

    // row * COLUMNS + col always fits here
    localparam int IDX_W   = ROW_W + COL_W;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    localparam int HOME_COL = (40 < COLUMNS) ? 40 : COLUMNS - 1;
    localparam int HOME_ROW = (12 < ROWS) ? 12 : ROWS - 1;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]        CH_NULL    = 8'h00;
    localparam logic [7:0]        CH_NEWLINE = 8'h0A;
    localparam logic [7:0]        CH_SPACE   = 8'h20;

    localparam logic [2:0] OP_PUT_CHAR   = 3'd0;
    localparam logic [2:0] OP_PTR_ACT    = 3'd1;
    localparam logic [2:0] OP_PTR_MOVE   = 3'd2;
    localparam logic [2:0] OP_CELL_WRITE = 3'd3;
    localparam logic [2:0] OP_CELL_READ  = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_SWAP  = 2'd1;
    localparam logic [1:0] MODE_BLANK = 2'd2;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        char_code;
        logic signed [7:0] delta_x;
        logic signed [7:0] delta_y;
        logic [ADDR_W-1:0] cell_address;
        logic [CELL_W-1:0] cell_data;
    } t_in_item;

    typedef struct packed {
        logic [CELL_W-1:0] read_data;
        logic [COL_W-1:0]  text_col;
        logic [ROW_W-1:0]  text_row;
        logic [COL_W-1:0]  pointer_col;
        logic [ROW_W-1:0]  pointer_row;
        logic              pointer_on;
    } t_out_item;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] addr;
        logic [CELL_W-1:0]  data;
    } t_wr_req;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] ch;
    } t_cell_op;

endpackage

// File: rtl/tcp_cmd_if.sv
// Command channel of the text console: valid/ready plus one input item.
// Depends on tcp_pkg.
interface tcp_cmd_if
    import tcp_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [7:0]          char_code;
    logic signed [7:0]   delta_x;
    logic signed [7:0]   delta_y;
    logic [ADDR_W-1:0]   cell_address;
    logic [CELL_W-1:0]   cell_data;

    modport source (
        output valid, opcode, char_code, delta_x, delta_y, cell_address, cell_data,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_code, delta_x, delta_y, cell_address, cell_data,
        output ready
    );
endinterface

// File: rtl/tcp_res_if.sv
// Result channel of the text console: valid/ready plus one result item.
// Depends on tcp_pkg.
interface tcp_res_if
    import tcp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CELL_W-1:0]  read_data;
    logic [COL_W-1:0]   text_col;
    logic [ROW_W-1:0]   text_row;
    logic [COL_W-1:0]   pointer_col;
    logic [ROW_W-1:0]   pointer_row;
    logic               pointer_on;

    modport source (
        output valid, read_data, text_col, text_row, pointer_col, pointer_row, pointer_on,
        input  ready
    );
    modport sink (
        input  valid, read_data, text_col, text_row, pointer_col, pointer_row, pointer_on,
        output ready
    );
endinterface

// File: rtl/tcp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tcp_cell_unit.sv
// Shared cell update unit: new character, attribute nibble swap or blank.
// Depends on tcp_pkg.
module tcp_cell_unit
    import tcp_pkg::*;
(
    input  logic [CELL_W-1:0] i_word,
    input  t_cell_op          i_op,
    output logic [CELL_W-1:0] o_word
);
    always_comb begin
        case (i_op.mode)
            MODE_CHAR:  o_word = {i_word[15:8], i_op.ch};
            MODE_SWAP:  o_word = {i_word[11:8], i_word[15:12], i_word[7:0]};
            MODE_BLANK: o_word = {i_word[15:8], CH_SPACE};
            default:    o_word = i_word;
        endcase
    end
endmodule

// File: rtl/tcp_ctrl.sv
// Sequencer of the text console: dispatch, read-modify-write of cells, memory sweeps,
// cursor and pointer state, and the result register. Depends on tcp_pkg.
module tcp_ctrl
    import tcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_in_item          i_item,
    output logic              o_ready,
    input  logic              i_res_ready,
    output logic              o_res_valid,
    output t_out_item         o_res,
    output t_rd_req           o_rd,
    output t_wr_req           o_wr,
    input  logic [CELL_W-1:0] i_rdata,
    output t_cell_op          o_cell_op,
    input  logic [CELL_W-1:0] i_cell_new
);
    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_RMW_RD   = 3'd2;
    localparam logic [2:0] S_RMW_WR   = 3'd3;
    localparam logic [2:0] S_READ_CAP = 3'd4;
    localparam logic [2:0] S_SWEEP    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CELL_AW-1:0] r_wr_addr, n_wr_addr;
    logic               r_wr_pend, n_wr_pend;
    logic [CELL_AW-1:0] r_addr, n_addr;
    logic [1:0]         r_mode, n_mode;
    logic [7:0]         r_ch, n_ch;
    logic               r_second, n_second;
    logic               r_blank, n_blank;
    logic [COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [COL_W-1:0]   r_ms_col, n_ms_col;
    logic [ROW_W-1:0]   r_ms_row, n_ms_row;
    logic               r_ms_on, n_ms_on;
    logic [CELL_W-1:0]  r_rd, n_rd;
    logic               r_res_valid, n_res_valid;
    t_out_item          r_res, n_res;

    logic [COL_W:0]     nc;
    logic [ROW_W:0]     nr;
    logic               addr_ok;

    // shared cell index: row * COLUMNS + col
    logic [ROW_W-1:0]   ix_row;
    logic [COL_W-1:0]   ix_col;
    logic [IDX_W-1:0]   ix_full;
    logic [CELL_AW-1:0] ix_cell;

    function automatic logic [7:0] f_step(input logic [7:0] pos, input logic [7:0] d,
                                          input logic sub, input int unsigned limit);
        logic [7:0] s;
        s = sub ? (pos - d) : (pos + d);
        if (s[7]) begin
            f_step = '0;
        end else if (32'(s) >= limit) begin
            f_step = 8'(limit - 1);
        end else begin
            f_step = s;
        end
    endfunction

    always_comb begin
        if (r_state == S_IDLE && i_item.opcode == OP_PUT_CHAR) begin
            ix_row = r_cur_row;
            ix_col = r_cur_col;
        end else if (r_state == S_IDLE && i_item.opcode == OP_PTR_ACT) begin
            ix_row = ROW_W'(HOME_ROW);
            ix_col = COL_W'(HOME_COL);
        end else begin
            ix_row = r_ms_row;
            ix_col = r_ms_col;
        end
        ix_full = IDX_W'(ix_row) * IDX_W'(COLUMNS) + IDX_W'(ix_col);
        ix_cell = (ix_full < IDX_W'(CELLS)) ? ix_full[CELL_AW-1:0] : '0;
    end

    assign addr_ok = IDX_W'(i_item.cell_address) < IDX_W'(CELLS);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_addr      = r_addr;
        n_mode      = r_mode;
        n_ch        = r_ch;
        n_second    = r_second;
        n_blank     = r_blank;
        n_cur_col   = r_cur_col;
        n_cur_row   = r_cur_row;
        n_ms_col    = r_ms_col;
        n_ms_row    = r_ms_row;
        n_ms_on     = r_ms_on;
        n_rd        = r_rd;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        nc          = {1'b0, r_cur_col};
        nr          = {1'b0, r_cur_row};
        o_rd        = '0;
        o_wr        = '0;

        if (r_res_valid && i_res_ready) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                o_wr.en   = 1'b1;
                o_wr.addr = CELL_AW'(r_cnt);
                o_wr.data = BLANK_CELL;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_rd     = '0;
                    n_second = 1'b0;
                    n_blank  = 1'b0;
                    n_state  = S_DONE;
                    case (i_item.opcode)
                        OP_PUT_CHAR: begin
                            if (i_item.char_code != CH_NULL) begin
                                if (i_item.char_code == CH_NEWLINE) begin
                                    nc = '0;
                                    nr = nr + (ROW_W+1)'(1);
                                end else begin
                                    nc = nc + (COL_W+1)'(1);
                                end
                                if (nc >= (COL_W+1)'(COLUMNS)) begin
                                    nc = '0;
                                    nr = nr + (ROW_W+1)'(1);
                                end
                                if (nr >= (ROW_W+1)'(ROWS)) begin
                                    n_blank = 1'b1;
                                    nc      = '0;
                                    nr      = '0;
                                end
                                n_cur_col = nc[COL_W-1:0];
                                n_cur_row = nr[ROW_W-1:0];
                                n_addr    = ix_cell;
                                n_mode    = MODE_CHAR;
                                n_ch      = i_item.char_code;
                                if (i_item.char_code != CH_NEWLINE) begin
                                    n_state = S_RMW_RD;
                                end else if (n_blank) begin
                                    n_blank   = 1'b0;
                                    n_cnt     = '0;
                                    n_wr_pend = 1'b0;
                                    n_state   = S_SWEEP;
                                end
                            end
                        end
                        OP_PTR_ACT: begin
                            n_ms_col = COL_W'(HOME_COL);
                            n_ms_row = ROW_W'(HOME_ROW);
                            n_ms_on  = 1'b1;
                            n_addr   = ix_cell;
                            n_mode   = MODE_SWAP;
                            n_state  = S_RMW_RD;
                        end
                        OP_PTR_MOVE: begin
                            // old cell first, new cell after the position update
                            n_ms_col = COL_W'(f_step(8'(r_ms_col), i_item.delta_x, 1'b0,
                                                     COLUMNS));
                            n_ms_row = ROW_W'(f_step(8'(r_ms_row), i_item.delta_y, 1'b1,
                                                     ROWS));
                            n_addr   = ix_cell;
                            n_mode   = MODE_SWAP;
                            n_second = r_ms_on;
                            if (r_ms_on) begin
                                n_state = S_RMW_RD;
                            end
                        end
                        OP_CELL_WRITE: begin
                            o_wr.en   = addr_ok;
                            o_wr.addr = CELL_AW'(i_item.cell_address);
                            o_wr.data = i_item.cell_data;
                        end
                        OP_CELL_READ: begin
                            if (addr_ok) begin
                                o_rd.en   = 1'b1;
                                o_rd.addr = CELL_AW'(i_item.cell_address);
                                n_state   = S_READ_CAP;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt     = '0;
                            n_wr_pend = 1'b0;
                            n_state   = S_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW_RD: begin
                o_rd.en   = 1'b1;
                o_rd.addr = r_addr;
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_addr;
                o_wr.data = i_cell_new;
                if (r_second) begin
                    n_second = 1'b0;
                    n_addr   = ix_cell;
                    n_state  = S_RMW_RD;
                end else if (r_blank) begin
                    n_blank   = 1'b0;
                    n_cnt     = '0;
                    n_wr_pend = 1'b0;
                    n_state   = S_SWEEP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ_CAP: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_SWEEP: begin
                // read cell n while writing back cell n-1
                o_rd.en   = r_cnt < CNT_W'(CELLS);
                o_rd.addr = CELL_AW'(r_cnt);
                o_wr.en   = r_wr_pend;
                o_wr.addr = r_wr_addr;
                o_wr.data = i_cell_new;
                n_wr_addr = CELL_AW'(r_cnt);
                n_wr_pend = r_cnt < CNT_W'(CELLS);
                if (r_cnt == CNT_W'(CELLS)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    n_res_valid       = 1'b1;
                    n_res.read_data   = r_rd;
                    n_res.text_col    = r_cur_col;
                    n_res.text_row    = r_cur_row;
                    n_res.pointer_col = r_ms_col;
                    n_res.pointer_row = r_ms_row;
                    n_res.pointer_on  = r_ms_on;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cell_op.mode = (r_state == S_SWEEP) ? MODE_BLANK : r_mode;
    assign o_cell_op.ch   = r_ch;
    assign o_ready        = (r_state == S_IDLE);
    assign o_res_valid    = r_res_valid;
    assign o_res          = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_wr_pend   <= 1'b0;
            r_second    <= 1'b0;
            r_blank     <= 1'b0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_ms_col    <= COL_W'(HOME_COL);
            r_ms_row    <= ROW_W'(HOME_ROW);
            r_ms_on     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wr_pend   <= n_wr_pend;
            r_second    <= n_second;
            r_blank     <= n_blank;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_ms_col    <= n_ms_col;
            r_ms_row    <= n_ms_row;
            r_ms_on     <= n_ms_on;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        r_addr    <= n_addr;
        r_mode    <= n_mode;
        r_ch      <= n_ch;
        r_rd      <= n_rd;
        r_res     <= n_res;
    end
endmodule

// File: rtl/text_console_with_pointer_top.sv
// Text console with pointer, top level. Depends on tcp_pkg, tcp_cmd_if, tcp_res_if,
// tcp_ram, tcp_cell_unit and tcp_ctrl.
// Clear and scroll sweep the whole cell memory, one cell per cycle through the single
// memory port pair. One command at a time; the next is taken after its result.
// Reset: cursor at 0,0, pointer at 40,12 hidden, then a fill of the cell memory with blanks.
module text_console_with_pointer_top
    import tcp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcp_cmd_if.sink   i_cmd,
    tcp_res_if.source o_res
);
    t_in_item          item;
    t_out_item         res;
    t_rd_req           rd_req;
    t_wr_req           wr_req;
    t_cell_op          cell_op;
    logic [CELL_W-1:0] rdata;
    logic [CELL_W-1:0] cell_new;
    logic              cmd_ready;
    logic              res_valid;

    assign item.opcode       = i_cmd.opcode;
    assign item.char_code    = i_cmd.char_code;
    assign item.delta_x      = i_cmd.delta_x;
    assign item.delta_y      = i_cmd.delta_y;
    assign item.cell_address = i_cmd.cell_address;
    assign item.cell_data    = i_cmd.cell_data;
    assign i_cmd.ready       = cmd_ready;

    assign o_res.valid       = res_valid;
    assign o_res.read_data   = res.read_data;
    assign o_res.text_col    = res.text_col;
    assign o_res.text_row    = res.text_row;
    assign o_res.pointer_col = res.pointer_col;
    assign o_res.pointer_row = res.pointer_row;
    assign o_res.pointer_on  = res.pointer_on;

    tcp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_req.en),
        .i_waddr (wr_req.addr),
        .i_wdata (wr_req.data),
        .i_re    (rd_req.en),
        .i_raddr (rd_req.addr),
        .o_rdata (rdata)
    );

    tcp_cell_unit u_cell (
        .i_word (rdata),
        .i_op   (cell_op),
        .o_word (cell_new)
    );

    tcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_cmd.valid),
        .i_item      (item),
        .o_ready     (cmd_ready),
        .i_res_ready (o_res.ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_rd        (rd_req),
        .o_wr        (wr_req),
        .i_rdata     (rdata),
        .o_cell_op   (cell_op),
        .i_cell_new  (cell_new)
    );

    // ready drops after every accepted command
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted on consecutive cycles");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.text_col < COL_W'(COLUMNS)) && (res.text_row < ROW_W'(ROWS)))
        else $error("text cursor out of screen");

    a_pointer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (res.pointer_col < COL_W'(COLUMNS)) && (res.pointer_row < ROW_W'(ROWS)))
        else $error("pointer out of screen");

    // the memory is never written and read at the same address in one cycle
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_req.en && rd_req.en |-> wr_req.addr != rd_req.addr)
        else $error("cell memory read and write collide");
endmodule

// File: bench/text_console_with_pointer_top_tb.sv
// Self-checking testbench for text_console_with_pointer_top: directed rows, then random traffic.
// A behavioral copy of the screen, cursor and pointer predicts the results that no directed row fixes.
// Depends on tcp_pkg, tcp_cmd_if, tcp_res_if and the RTL of the block.
`timescale 1ns / 100ps

module text_console_with_pointer_top_tb;
    import tcp_pkg::*;

    localparam int     RANDOM_ITEMS = 1350;
    localparam longint CYCLE_LIMIT  = 64'd1500 * (CELLS + 140) * 3;

    typedef struct {
        t_in_item  cmd;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    tcp_cmd_if cmd_if();
    tcp_res_if res_if();

    text_console_with_pointer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // screen shadow and cursor/pointer state
    logic [CELL_W-1:0] shadow_cells [CELLS];
    int                cur_col, cur_row, ptr_col, ptr_row;
    bit                ptr_shown;

    t_out_item     expected_reports [$];
    t_out_item     front_report;
    t_directed_row directed_rows [$];

    int     err_count, results_checked, scroll_count, wrap_count;
    int     op_seen [8];
    longint cycle_count;
    int     stall_left;
    bit     send_quiet;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_console_with_pointer_top_tb: errors");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    task automatic blank_shadow();
        for (int k = 0; k < CELLS; k++)
            shadow_cells[k] = {shadow_cells[k][15:8], CH_SPACE};
    endtask

    task automatic swap_attr(input int idx);
        logic [CELL_W-1:0] v;
        v = shadow_cells[idx];
        shadow_cells[idx] = {v[11:8], v[15:12], v[7:0]};
    endtask

    // 8-bit wrapped position: negative goes to 0, past the edge to the last line/column
    function automatic int clamp_step(input logic [7:0] s, input int lim);
        if (s[7])
            return 0;
        if (int'(s) >= lim)
            return lim - 1;
        return int'(s);
    endfunction

    task automatic console_predict(input t_in_item c, output t_out_item r);
        int         idx;
        logic [7:0] s;
        r = '0;
        op_seen[c.opcode]++;
        case (c.opcode)
            OP_PUT_CHAR: begin
                if (c.char_code != CH_NULL) begin
                    if (c.char_code == CH_NEWLINE) begin
                        cur_col = 0;
                        cur_row++;
                    end else begin
                        idx = cur_row * COLUMNS + cur_col;
                        shadow_cells[idx] = {shadow_cells[idx][15:8], c.char_code};
                        cur_col++;
                    end
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                        wrap_count++;
                    end
                    if (cur_row >= ROWS) begin
                        blank_shadow();
                        cur_col = 0;
                        cur_row = 0;
                        scroll_count++;
                    end
                end
            end
            OP_PTR_ACT: begin
                ptr_col = HOME_COL;
                ptr_row = HOME_ROW;
                swap_attr(ptr_row * COLUMNS + ptr_col);
                ptr_shown = 1'b1;
            end
            OP_PTR_MOVE: begin
                if (ptr_shown)
                    swap_attr(ptr_row * COLUMNS + ptr_col);
                s = 8'(ptr_col) + unsigned'(c.delta_x);
                ptr_col = clamp_step(s, COLUMNS);
                s = 8'(ptr_row) - unsigned'(c.delta_y);
                ptr_row = clamp_step(s, ROWS);
                if (ptr_shown)
                    swap_attr(ptr_row * COLUMNS + ptr_col);
            end
            OP_CELL_WRITE: begin
                if (c.cell_address < CELLS)
                    shadow_cells[c.cell_address] = c.cell_data;
            end
            OP_CELL_READ: begin
                if (c.cell_address < CELLS)
                    r.read_data = shadow_cells[c.cell_address];
            end
            OP_CLEAR: blank_shadow();
            default: ;
        endcase
        r.text_col    = COL_W'(cur_col);
        r.text_row    = ROW_W'(cur_row);
        r.pointer_col = COL_W'(ptr_col);
        r.pointer_row = ROW_W'(ptr_row);
        r.pointer_on  = ptr_shown;
    endtask

    // ---------------- result checking ----------------

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_reports.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                front_report = expected_reports.pop_front();
                check_field("read_data", front_report.read_data, res_if.read_data);
                check_field("text_col", front_report.text_col, res_if.text_col);
                check_field("text_row", front_report.text_row, res_if.text_row);
                check_field("pointer_col", front_report.pointer_col, res_if.pointer_col);
                check_field("pointer_row", front_report.pointer_row, res_if.pointer_row);
                check_field("pointer_on", front_report.pointer_on, res_if.pointer_on);
                results_checked++;
            end
        end
    end

    // ---------------- idling ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver stalls, with recurring stall-free stretches
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else begin
            res_if.ready <= 1'b1;
            if ((cycle_count / 700) % 4 != 0 && $urandom_range(0, 5) == 0)
                stall_left = pick_gap();
        end
    end

    // ---------------- command side ----------------

    function automatic t_in_item mk_cmd(input logic [2:0] op, input logic [7:0] ch,
                                        input logic [7:0] dx, dy,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [CELL_W-1:0] data);
        t_in_item c;
        c.opcode       = op;
        c.char_code    = ch;
        c.delta_x      = dx;
        c.delta_y      = dy;
        c.cell_address = addr;
        c.cell_data    = data;
        return c;
    endfunction

    function automatic t_out_item mk_res(input logic [CELL_W-1:0] rd, input int tc, tr,
                                         input int pc, pr, input bit on);
        t_out_item r;
        r.read_data   = rd;
        r.text_col    = COL_W'(tc);
        r.text_row    = ROW_W'(tr);
        r.pointer_col = COL_W'(pc);
        r.pointer_row = ROW_W'(pr);
        r.pointer_on  = on;
        return r;
    endfunction

    task automatic add_row(input t_in_item c, input bit typed = 1'b0,
                           input t_out_item want = '0);
        t_directed_row row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Entered just after the previous transfer; valid is only lowered when a gap follows.
    task automatic send_cmd(input t_in_item c, input int gap, input bit typed = 1'b0,
                            input t_out_item want = '0);
        t_out_item pred;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.opcode       <= c.opcode;
        cmd_if.char_code    <= c.char_code;
        cmd_if.delta_x      <= c.delta_x;
        cmd_if.delta_y      <= c.delta_y;
        cmd_if.cell_address <= c.cell_address;
        cmd_if.cell_data    <= c.cell_data;
        cmd_if.valid        <= 1'b1;
        do @(posedge i_clk); while (!cmd_if.ready);
        console_predict(c, pred);
        expected_reports.push_back(typed ? want : pred);
    endtask

    task automatic hold_off_until_empty();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic t_in_item rand_fields();
        return mk_cmd(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      ADDR_W'($urandom), CELL_W'($urandom));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        if ($urandom_range(0, 9) == 0)
            return ADDR_W'($urandom_range(CELLS, 2 ** ADDR_W - 1));
        return ADDR_W'($urandom_range(0, CELLS - 1));
    endfunction

    function automatic logic [7:0] rand_delta();
        if ($urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, 6) - 3);
        return 8'($urandom);
    endfunction

    initial begin
        int          random_sent;
        int          kind, len, j;
        bit          paused;
        t_in_item    c;
        logic [ADDR_W-1:0] last_addr;

        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.opcode       = OP_PUT_CHAR;
        cmd_if.char_code    = CH_NULL;
        cmd_if.delta_x      = '0;
        cmd_if.delta_y      = '0;
        cmd_if.cell_address = '0;
        cmd_if.cell_data    = '0;
        res_if.ready        = 1'b0;
        for (int k = 0; k < CELLS; k++)
            shadow_cells[k] = BLANK_CELL;
        cur_col   = 0;
        cur_row   = 0;
        ptr_col   = HOME_COL;
        ptr_row   = HOME_ROW;
        ptr_shown = 1'b0;
        last_addr = '0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // after reset, address extremes, out-of-range access
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(BLANK_CELL, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd1999, 16'h0000), 1,
                mk_res(BLANK_CELL, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd2047, 16'hFFFF), 1,
                mk_res(16'h0000, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_WRITE, 8'h00, 8'h00, 8'h00, 11'd2047, 16'hFFFF), 1,
                mk_res(16'h0000, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_WRITE, 8'h00, 8'h00, 8'h00, 11'd0, 16'hABCD), 1,
                mk_res(16'h0000, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'hABCD, 0, 0, HOME_COL, HOME_ROW, 0));
        // text: null, printable extremes, newline
        add_row(mk_cmd(OP_PUT_CHAR, CH_NULL, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'h0000, 0, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_PUT_CHAR, 8'h41, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'h0000, 1, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_PUT_CHAR, 8'hFF, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'h0000, 2, 0, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_PUT_CHAR, CH_NEWLINE, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'h0000, 0, 1, HOME_COL, HOME_ROW, 0));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000));
        // moves while hidden, delta extremes and clamping
        add_row(mk_cmd(OP_PTR_MOVE, 8'h00, 8'h7F, 8'h80, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_PTR_MOVE, 8'h00, 8'h80, 8'h7F, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_PTR_MOVE, 8'h00, 8'd79, 8'hE8, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_PTR_ACT, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000), 1,
                mk_res(16'h0000, 0, 1, HOME_COL, HOME_ROW, 1));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'(HOME_ROW * COLUMNS + HOME_COL),
                       16'h0000));
        // activate while already shown swaps the home cell back
        add_row(mk_cmd(OP_PTR_ACT, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_PTR_MOVE, 8'h00, 8'd100, 8'h9C, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'(HOME_ROW * COLUMNS + HOME_COL),
                       16'h0000));
        add_row(mk_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd1, 16'h0000));
        add_row(mk_cmd(3'd6, 8'hFF, 8'hFF, 8'hFF, 11'h7FF, 16'hFFFF));
        add_row(mk_cmd(3'd7, 8'h00, 8'h00, 8'h00, 11'd0, 16'h0000));
        add_row(mk_cmd(OP_CELL_WRITE, 8'h00, 8'h00, 8'h00, 11'd1999, 16'h0000));
        add_row(mk_cmd(OP_CELL_READ, 8'h00, 8'h00, 8'h00, 11'd1999, 16'h0000));

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, pick_gap(), directed_rows[i].typed,
                     directed_rows[i].want);
        hold_off_until_empty();

        random_sent = 0;
        paused      = 1'b0;
        while (random_sent < RANDOM_ITEMS) begin
            send_quiet = ($urandom_range(0, 3) == 0);
            kind       = $urandom_range(0, 99);
            if (kind < 45) begin
                // text burst; now and then a long run without newline to force a wrap
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(81, 90)
                                                   : $urandom_range(1, 20);
                for (j = 0; j < len; j++) begin
                    c        = rand_fields();
                    c.opcode = OP_PUT_CHAR;
                    if (len > 80)
                        c.char_code = 8'($urandom_range(32, 126));
                    else if ($urandom_range(0, 99) < 12)
                        c.char_code = CH_NEWLINE;
                    else if ($urandom_range(0, 99) < 3)
                        c.char_code = CH_NULL;
                    else
                        c.char_code = 8'($urandom_range(1, 255));
                    send_cmd(c, send_quiet ? 0 : pick_gap());
                    if (c.char_code != CH_NULL)
                        random_sent++;
                end
            end else if (kind < 65) begin
                if ($urandom_range(0, 4) == 0) begin
                    c        = rand_fields();
                    c.opcode = OP_PTR_ACT;
                    send_cmd(c, send_quiet ? 0 : pick_gap());
                    random_sent++;
                end
                len = $urandom_range(1, 6);
                for (j = 0; j < len; j++) begin
                    c         = rand_fields();
                    c.opcode  = OP_PTR_MOVE;
                    c.delta_x = rand_delta();
                    c.delta_y = rand_delta();
                    send_cmd(c, send_quiet ? 0 : pick_gap());
                    random_sent++;
                end
            end else if (kind < 88) begin
                len = $urandom_range(1, 6);
                for (j = 0; j < len; j++) begin
                    c = rand_fields();
                    if ($urandom_range(0, 2) != 0)
                        last_addr = rand_addr();
                    c.cell_address = last_addr;
                    c.opcode = $urandom_range(0, 1) ? OP_CELL_WRITE : OP_CELL_READ;
                    send_cmd(c, send_quiet ? 0 : pick_gap());
                    random_sent++;
                end
            end else if (kind < 93) begin
                c        = rand_fields();
                c.opcode = OP_CLEAR;
                send_cmd(c, send_quiet ? 0 : pick_gap());
                random_sent++;
            end else begin
                // noise: any opcode, any field content
                c = rand_fields();
                send_cmd(c, send_quiet ? 0 : pick_gap());
                if (!(c.opcode > OP_CLEAR ||
                      (c.opcode == OP_PUT_CHAR && c.char_code == CH_NULL)))
                    random_sent++;
            end
            if (!paused && random_sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                hold_off_until_empty();
            end
        end

        hold_off_until_empty();
        repeat (12) @(negedge i_clk);

        $display("run: %0d put, %0d activate, %0d move, %0d write, %0d read, %0d clear, %0d other",
                 op_seen[OP_PUT_CHAR], op_seen[OP_PTR_ACT], op_seen[OP_PTR_MOVE],
                 op_seen[OP_CELL_WRITE], op_seen[OP_CELL_READ], op_seen[OP_CLEAR],
                 op_seen[6] + op_seen[7]);
        $display("%0d results checked, %0d line wraps, %0d screen scrolls",
                 results_checked, wrap_count, scroll_count);
        if (err_count == 0)
            $display("text_console_with_pointer_top_tb: clean");
        else
            $display("text_console_with_pointer_top_tb: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/tcp_pkg.sv
rtl/tcp_cmd_if.sv
rtl/tcp_res_if.sv
rtl/tcp_ram.sv
rtl/tcp_cell_unit.sv
rtl/tcp_ctrl.sv
rtl/text_console_with_pointer_top.sv
bench/text_console_with_pointer_top_tb.sv
